// ----- rtl/core/utf8dec_pkg.sv -----
`default_nettype none

package utf8dec_pkg;

    localparam int BYTE_W  = 8;
    localparam int UNIT_W  = 16;
    localparam int COUNT_W = 3;

    localparam logic [BYTE_W-1:0] CONT_MASK  = 8'h3F;
    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'h1F;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'h0F;

    // Sequence lengths; the longest one that still carries payload bits is four.
    localparam logic [COUNT_W-1:0] LEN_ONE     = 3'd1;
    localparam logic [COUNT_W-1:0] LEN_TWO     = 3'd2;
    localparam logic [COUNT_W-1:0] LEN_THREE   = 3'd3;
    localparam logic [COUNT_W-1:0] LEN_FOUR    = 3'd4;
    localparam logic [COUNT_W-1:0] LEN_FIVE    = 3'd5;
    localparam logic [COUNT_W-1:0] LEN_SIX     = 3'd6;
    localparam logic [COUNT_W-1:0] LEN_MAX_PAY = LEN_FOUR;

    typedef logic [BYTE_W-1:0]  t_byte;
    typedef logic [UNIT_W-1:0]  t_unit;
    typedef logic [COUNT_W-1:0] t_count;

    function automatic t_count lead_length(input t_byte b);
        t_count len;
        if (b < 8'hC0)      len = LEN_ONE;
        else if (b < 8'hE0) len = LEN_TWO;
        else if (b < 8'hF0) len = LEN_THREE;
        else if (b < 8'hF8) len = LEN_FOUR;
        else if (b < 8'hFC) len = LEN_FIVE;
        else                len = LEN_SIX;
        return len;
    endfunction

    function automatic t_unit lead_bits(input t_byte b, input t_count len);
        t_unit bits;
        case (len)
            LEN_ONE:   bits = {8'h00, b};
            LEN_TWO:   bits = {5'd0, b[4:0] & LEAD2_MASK[4:0], 6'd0};
            LEN_THREE: bits = {b[3:0] & LEAD3_MASK[3:0], 12'd0};
            default:   bits = '0;
        endcase
        return bits;
    endfunction

    // Place the six payload bits of a continuation byte; left is the count
    // of bytes still to come after this one.
    function automatic t_unit cont_bits(input t_byte b, input t_count left);
        t_unit    bits;
        logic [5:0] pay;
        pay = b[5:0] & CONT_MASK[5:0];
        case (left)
            3'd0:    bits = {10'd0, pay};
            3'd1:    bits = {4'd0, pay, 6'd0};
            3'd2:    bits = {pay[3:0], 12'd0};
            default: bits = '0;
        endcase
        return bits;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/utf8_to_ucs2_decoder_top.sv -----
// The completing input beat is taken into the input register; its code unit is then
// written to the result register, which drives the output (a stall can hold it).
// Throughput: one byte per cycle; the input register and the result register
// each hand on a beat every cycle while the output side takes beats.
// Reset: synchronous, active low; clears the decoder state (idle, no partial
// unit) and both valid flags.
`default_nettype none

module utf8_to_ucs2_decoder_top
    import utf8dec_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] in_byte
    input  wire logic        i_s_axis_tlast,   // end_of_string
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [15:0]      o_m_axis_tdata,   // [15:0] code_unit
    output logic             o_m_axis_tlast,   // last_unit
    output logic             o_m_axis_tuser    // [0] truncated
);

    logic   r_in_valid;
    t_byte  r_in_byte;
    logic   r_in_last;

    t_count r_bytes_left, n_bytes_left;
    t_count r_seq_len,    n_seq_len;
    t_unit  r_partial,    n_partial;

    logic   r_out_valid;
    t_unit  r_out_unit;
    logic   r_out_last;
    logic   r_out_trunc;

    t_count step_left;
    t_count step_len;
    t_unit  step_partial;
    logic   step_done;
    logic   step_emit;
    logic   out_free;
    logic   advance;

    always_comb begin
        if (r_bytes_left == '0) begin
            step_len     = lead_length(r_in_byte);
            step_left    = step_len - 3'd1;
            step_partial = lead_bits(r_in_byte, step_len);
        end else begin
            step_len  = r_seq_len;
            step_left = r_bytes_left - 3'd1;
            if (r_seq_len <= LEN_MAX_PAY) begin
                step_partial = r_partial | cont_bits(r_in_byte, step_left);
            end else begin
                step_partial = r_partial;
            end
        end
        step_done = (step_left == '0);
        step_emit = step_done || r_in_last;
    end

    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign advance         = r_in_valid && (!step_emit || out_free);
    assign o_s_axis_tready = !r_in_valid || advance;

    always_comb begin
        n_bytes_left = r_bytes_left;
        n_seq_len    = r_seq_len;
        n_partial    = r_partial;
        if (advance) begin
            if (step_emit) begin
                n_bytes_left = '0;
                n_seq_len    = '0;
                n_partial    = '0;
            end else begin
                n_bytes_left = step_left;
                n_seq_len    = step_len;
                n_partial    = step_partial;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_bytes_left <= '0;
            r_seq_len    <= '0;
            r_partial    <= '0;
        end else begin
            r_bytes_left <= n_bytes_left;
            r_seq_len    <= n_seq_len;
            r_partial    <= n_partial;
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (advance && step_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
        if (advance && step_emit) begin
            r_out_unit  <= step_partial;
            r_out_last  <= r_in_last;
            r_out_trunc <= !step_done;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_unit;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tuser  = r_out_trunc;

    // A sequence is open exactly when bytes are still expected.
    a_idle_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bytes_left == '0) == (r_seq_len == '0))
        else $error("sequence length and remaining count disagree");

    a_left_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bytes_left < r_seq_len || r_seq_len == '0)
        else $error("remaining count exceeds sequence length");

    a_long_seq_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seq_len > LEN_MAX_PAY |-> r_partial == '0)
        else $error("five or six byte sequence gathered payload bits");

    a_trunc_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tlast)
        else $error("truncated unit not marked as last");

endmodule

`default_nettype wire
